// ----- design/u8d_pkg.sv -----
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int CP_W          = 21;
    localparam int NRES_W        = 3;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00fffd;

    // lead byte classes
    localparam logic [2:0] CLS_BAD   = 3'd0;
    localparam logic [2:0] CLS_ASCII = 3'd1;
    localparam logic [2:0] CLS_LEAD2 = 3'd2;
    localparam logic [2:0] CLS_LEAD3 = 3'd3;
    localparam logic [2:0] CLS_LEAD4 = 3'd4;

    // one job for the back end: nres words, all replacements but the last
    typedef struct packed {
        logic [NRES_W-1:0] nres;
        logic [CP_W-1:0]   last_cp;
    } job_t;

    function automatic logic [2:0] lead_class(input logic [7:0] b);
        logic [2:0] cls;
        if (b[7] == 1'b0) begin
            cls = CLS_ASCII;
        end else if (b[7:5] == 3'b110) begin
            cls = CLS_LEAD2;
        end else if (b[7:4] == 4'b1110) begin
            cls = CLS_LEAD3;
        end else if (b[7:3] == 5'b11110) begin
            cls = CLS_LEAD4;
        end else begin
            cls = CLS_BAD;
        end
        return cls;
    endfunction

endpackage

// ----- design/utf8_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder with U+FFFD replacement.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue has room and returns one code
// point word per cycle while m_ready holds. A byte causes zero to four words;
// the front end turns a byte with any words into a single job in the same
// cycle, and the back end emits that job's words one per cycle unless m_ready
// is low. A queue of QUEUE_DEPTH jobs between the two absorbs such bursts;
// input stalls only when it fills. A byte's job is registered in the queue
// and then loaded into the back end's registers before its first word is
// offered. Malformed or cut-short sequences yield U+FFFD per buffered byte.
module utf8_stream_decoder
    import u8d_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_text_byte,
    input  logic            s_end_of_text,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_codepoint,
    output logic            m_last_of_run
);

    logic q_full, q_push, q_pop, q_not_empty;
    job_t push_job, head_job;

    u8d_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    u8d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_head        (head_job),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_codepoint   (m_codepoint),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ----- design/u8d_front.sv -----
// ----------------------------------------------------------------------------
// u8d_front
// Accepts bytes, tracks the open sequence and turns each byte into a job.
// ----------------------------------------------------------------------------
module u8d_front
    import u8d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_text,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    logic [7:0] pend0_reg, pend1_reg, pend2_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] exp_len_reg, exp_len_next;
    logic       accept;
    logic       is_cont;
    logic [2:0] cls;
    logic       fresh_res;
    logic [CP_W-1:0] fresh_cp;
    logic       fresh_open;
    logic [CP_W-1:0] asm_cp;
    logic       wr_p0, wr_p1, wr_p2;
    job_t       job;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_cont = (s_text_byte[7:6] == 2'b10);
    assign cls     = lead_class(s_text_byte);

    always_comb begin
        fresh_res  = 1'b1;
        fresh_cp   = REPLACEMENT_CP;
        fresh_open = 1'b0;
        if (cls == CLS_ASCII) begin
            fresh_cp = {13'd0, s_text_byte};
        end else if (cls == CLS_BAD || s_end_of_text) begin
            fresh_cp = REPLACEMENT_CP;
        end else begin
            fresh_res  = 1'b0;
            fresh_open = 1'b1;
        end
    end

    always_comb begin
        case (exp_len_reg)
            CLS_LEAD2: asm_cp = {10'd0, pend0_reg[4:0], s_text_byte[5:0]};
            CLS_LEAD3: asm_cp = {5'd0, pend0_reg[3:0], pend1_reg[5:0], s_text_byte[5:0]};
            default:   asm_cp = {pend0_reg[2:0], pend1_reg[5:0], pend2_reg[5:0],
                                 s_text_byte[5:0]};
        endcase
    end

    always_comb begin
        cnt_next     = cnt_reg;
        exp_len_next = exp_len_reg;
        job.nres     = '0;
        job.last_cp  = REPLACEMENT_CP;
        wr_p0        = 1'b0;
        wr_p1        = 1'b0;
        wr_p2        = 1'b0;
        if (exp_len_reg != 3'd0 && is_cont) begin
            if ({1'b0, cnt_reg} + 3'd1 == exp_len_reg) begin
                job.nres     = 3'd1;
                job.last_cp  = asm_cp;
                cnt_next     = 2'd0;
                exp_len_next = 3'd0;
            end else if (s_end_of_text || cnt_reg == 2'd3
                         || {1'b0, cnt_reg} + 3'd1 > exp_len_reg) begin
                // cut short: every buffered byte and this one are replaced
                job.nres     = {1'b0, cnt_reg} + 3'd1;
                cnt_next     = 2'd0;
                exp_len_next = 3'd0;
            end else begin
                wr_p1    = (cnt_reg == 2'd1);
                wr_p2    = (cnt_reg == 2'd2);
                cnt_next = cnt_reg + 2'd1;
            end
        end else begin
            // broken sequence (if open) flushes, then the byte starts afresh
            job.nres    = (exp_len_reg != 3'd0 ? {1'b0, cnt_reg} : 3'd0)
                          + {2'd0, fresh_res};
            job.last_cp = fresh_res ? fresh_cp : REPLACEMENT_CP;
            if (fresh_open) begin
                wr_p0        = 1'b1;
                cnt_next     = 2'd1;
                exp_len_next = cls;
            end else begin
                cnt_next     = 2'd0;
                exp_len_next = 3'd0;
            end
        end
        if (s_end_of_text) begin
            cnt_next     = 2'd0;
            exp_len_next = 3'd0;
        end
    end

    assign q_push = accept && (job.nres != '0);
    assign q_job  = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= 2'd0;
            exp_len_reg <= 3'd0;
        end else if (accept) begin
            cnt_reg     <= cnt_next;
            exp_len_reg <= exp_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && wr_p0) begin
            pend0_reg <= s_text_byte;
        end
        if (accept && wr_p1) begin
            pend1_reg <= s_text_byte;
        end
        if (accept && wr_p2) begin
            pend2_reg <= s_text_byte;
        end
    end

`ifndef SYNTHESIS
    a_open_count: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_len_reg != 3'd0 |-> cnt_reg != 2'd0 && {1'b0, cnt_reg} < exp_len_reg)
        else $error("open sequence with bad pending count");
    a_closed_count: assert property (@(posedge aclk) disable iff (!aresetn)
        exp_len_reg == 3'd0 |-> cnt_reg == 2'd0)
        else $error("pending bytes with no open sequence");
    a_eot_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_text |=> exp_len_reg == 3'd0)
        else $error("sequence left open after end of text");
`endif

endmodule

// ----- design/u8d_queue.sv -----
// ----------------------------------------------------------------------------
// u8d_queue
// Short job queue between the byte front end and the word back end.
// ----------------------------------------------------------------------------
module u8d_queue
    import u8d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head_job  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- design/u8d_back.sv -----
// ----------------------------------------------------------------------------
// u8d_back
// Expands each job into its words: replacements first, then the last word.
// ----------------------------------------------------------------------------
module u8d_back
    import u8d_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_not_empty,
    input  job_t            q_head,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_codepoint,
    output logic            m_last_of_run
);

    logic              busy_reg;
    logic [NRES_W-1:0] left_reg;
    logic [CP_W-1:0]   cp_reg;
    logic              at_last;
    logic              done;

    assign at_last = (left_reg == NRES_W'(1));
    assign done    = m_ready && at_last;
    assign q_pop   = q_not_empty && (!busy_reg || done);

    assign m_valid       = busy_reg;
    assign m_codepoint   = at_last ? cp_reg : REPLACEMENT_CP;
    assign m_last_of_run = at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            left_reg <= '0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            left_reg <= q_head.nres;
        end else if (busy_reg && m_ready) begin
            left_reg <= left_reg - NRES_W'(1);
            if (at_last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cp_reg <= q_head.last_cp;
        end
    end

`ifndef SYNTHESIS
    a_busy_left: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> left_reg != '0 && left_reg <= NRES_W'(4))
        else $error("word counter out of range while busy");
    a_pop_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !busy_reg || (m_ready && at_last))
        else $error("job popped while words remain");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder testbench
// Streams directed and random UTF-8 text into the decoder and checks every
// code point word against a local decoder with its own sequence state.
// ----------------------------------------------------------------------------

import u8d_pkg::*;

class codepoint_tracker;

    typedef struct {
        logic [CP_W-1:0] cp;
        logic            last;
    } word_t;

    word_t      expected_words[$];
    logic [7:0] held[3];
    int         held_cnt;
    int         seq_len;
    int         mismatches;

    function new();
        held_cnt   = 0;
        seq_len    = 0;
        mismatches = 0;
    endfunction

    task report(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function void push_cp(input logic [CP_W-1:0] cp);
        word_t w;
        w.cp   = cp;
        w.last = 1'b0;
        expected_words.push_back(w);
    endfunction

    // 1 for ascii, 2..4 for a lead byte, 0 for a stray byte
    function int byte_kind(input logic [7:0] b);
        if (b[7] == 1'b0) return 1;
        if (b[7:5] == 3'b110) return 2;
        if (b[7:4] == 4'b1110) return 3;
        if (b[7:3] == 5'b11110) return 4;
        return 0;
    endfunction

    function logic [CP_W-1:0] join_bytes(input logic [7:0] b);
        case (seq_len)
            2: return {10'd0, held[0][4:0], b[5:0]};
            3: return {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
            default: return {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
        endcase
    endfunction

    function void close_seq();
        held_cnt = 0;
        seq_len  = 0;
    endfunction

    function void start_fresh(input logic [7:0] b, input logic eot);
        int kind;
        kind = byte_kind(b);
        if (kind == 1) begin
            push_cp({13'd0, b});
        end else if (kind == 0 || eot) begin
            push_cp(REPLACEMENT_CP);
        end else begin
            held[0]  = b;
            held_cnt = 1;
            seq_len  = kind;
        end
    endfunction

    function void note_byte(input logic [7:0] b, input logic eot);
        int first;
        first = expected_words.size();
        if (seq_len != 0) begin
            if (b[7:6] == 2'b10) begin
                if (held_cnt + 1 == seq_len) begin
                    push_cp(join_bytes(b));
                    close_seq();
                end else if (eot || held_cnt + 1 > seq_len || held_cnt >= 3) begin
                    // cut short: every held byte and this one are replaced
                    repeat (held_cnt + 1) push_cp(REPLACEMENT_CP);
                    close_seq();
                end else begin
                    held[held_cnt] = b;
                    held_cnt++;
                end
            end else begin
                // broken sequence, then the breaking byte starts over
                repeat (held_cnt) push_cp(REPLACEMENT_CP);
                close_seq();
                start_fresh(b, eot);
            end
        end else begin
            start_fresh(b, eot);
        end
        if (eot) close_seq();
        if (expected_words.size() > first)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    task check_word(input logic [CP_W-1:0] cp, input logic last);
        word_t w;
        if (expected_words.size() == 0) begin
            report($sformatf("word %06h arrived with nothing expected", cp));
        end else begin
            w = expected_words.pop_front();
            if (cp !== w.cp)
                report($sformatf("codepoint %06h, expected %06h", cp, w.cp));
            if (last !== w.last)
                report($sformatf("last_of_run %b, expected %b on %06h", last, w.last, w.cp));
        end
    endtask

    task check_drained();
        if (expected_words.size() != 0)
            report($sformatf("%0d words never arrived", expected_words.size()));
    endtask

endclass

module testbench;

    localparam int RANDOM_ITEMS  = 405;
    localparam int OPENING_ITEMS = 25;
    localparam int CYCLE_LIMIT   = 100000;

    logic            aclk = 1'b0;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    logic [7:0]      s_text_byte;
    logic            s_end_of_text;
    logic            m_valid;
    logic            m_ready;
    logic [CP_W-1:0] m_codepoint;
    logic            m_last_of_run;

    bit quiet;
    int sent_items;
    int cycle_count;

    codepoint_tracker decoded = new();

    // {end_of_text, text_byte}
    logic [8:0] opening_bytes [OPENING_ITEMS] = '{
        9'h000, 9'h07f,
        9'h0e2, 9'h082, 9'h0ac,
        9'h0f0, 9'h09f, 9'h098, 9'h080,
        9'h0f7, 9'h0bf, 9'h0bf, 9'h0bf,
        9'h080, 9'h0ff,
        9'h0c3, 9'h041,
        9'h0f0, 9'h09f, 9'h0c2, 9'h0a9,
        9'h0f0, 9'h09f, 9'h198,
        9'h1c3
    };

    utf8_stream_decoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_codepoint   (m_codepoint),
        .m_last_of_run (m_last_of_run)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function bit take_break();
        return !quiet && ($urandom_range(99) < 37);
    endfunction

    always @(negedge aclk) begin
        m_ready <= !take_break();
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            decoded.check_word(m_codepoint, m_last_of_run);
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while (take_break()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_text_byte   <= b;
        s_end_of_text <= eot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decoded.note_byte(b, eot);
        sent_items++;
        @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (decoded.expected_words.size() != 0);
    endtask

    function logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(63))};
    endfunction

    function logic [7:0] lead_byte(input int len);
        case (len)
            1: return {1'b0, 7'($urandom_range(127))};
            2: return {3'b110, 5'($urandom_range(31))};
            3: return {4'b1110, 4'($urandom_range(15))};
            default: return {5'b11110, 3'($urandom_range(7))};
        endcase
    endfunction

    task automatic send_run();
        int pick;
        int len;
        int keep;
        int i;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 70) begin
            len = $urandom_range(4, 1);
            send_byte(lead_byte(len), len == 1 && $urandom_range(9) == 0);
            for (i = 1; i < len; i++)
                send_byte(cont_byte(), i == len - 1 && $urandom_range(9) == 0);
        end else if (pick < 85) begin
            len  = $urandom_range(4, 2);
            keep = $urandom_range(len - 2, 0);
            if ($urandom_range(1) == 1) begin
                // string ends inside the sequence
                send_byte(lead_byte(len), keep == 0);
                for (i = 1; i <= keep; i++)
                    send_byte(cont_byte(), i == keep);
            end else begin
                send_byte(lead_byte(len), 1'b0);
                for (i = 1; i <= keep; i++)
                    send_byte(cont_byte(), 1'b0);
                b = 8'($urandom_range(255));
                if (b[7:6] == 2'b10) b[6] = 1'b1;
                send_byte(b, $urandom_range(3) == 0);
            end
        end else begin
            send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("utf8_stream_decoder regression: fail");
        $finish;
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_text_byte   = 8'h00;
        s_end_of_text = 1'b0;
        m_ready       = 1'b0;
        quiet         = 1'b0;
        sent_items    = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (opening_bytes[i])
            send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
        pause_until_drained();

        while (sent_items < OPENING_ITEMS + RANDOM_ITEMS) begin
            // a stretch with both sides running flat out
            quiet = (sent_items >= 180 && sent_items < 280);
            if ($urandom_range(49) == 0) pause_until_drained();
            send_run();
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        while (decoded.expected_words.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        decoded.check_drained();

        if (decoded.mismatches == 0) begin
            $display("utf8_stream_decoder regression: pass");
        end else begin
            $display("utf8_stream_decoder regression: fail");
        end
        $finish;
    end

endmodule
